### rtl/qbp_pkg.sv
// types and constants shared by the quadratic b-spline point generator
// no dependencies; imported by every module of the block except qbp_fifo
package qbp_pkg;

    localparam int PT_W     = 16;        // control point and result coordinate width
    localparam int WGT_W    = 10;        // blend weight width, holds up to the scale
    localparam int SCALE    = 1000;      // weights are in thousandths
    localparam int HALF     = 500;       // rounding bias
    localparam int RECIP    = 33554;     // floor(2^25 / 1000)
    localparam int RECIP_W  = 16;
    localparam int RECIP_SH = 25;
    localparam int LANE_LAT = 5;         // register stages through one coordinate lane
    localparam int CMD_DEPTH = 2;        // front to back job queue
    localparam int OUT_DEPTH = 8;        // result queue

    typedef logic signed [PT_W-1:0] coord_t;

    typedef enum logic [1:0] {
        CFG_OFFSET_X = 2'd0,
        CFG_OFFSET_Y = 2'd1,
        CFG_PIXEL_FN = 2'd2
    } cfg_reg_e;

    // one job per accepted item: a move or a segment, optionally a closing segment
    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t cx;
        coord_t cy;
        logic   is_move;
        logic   close;
        logic   last_point;
    } job_t;

    typedef struct packed {
        logic valid;
        logic pen_move;
        logic curve_end;
        logic last;
    } tag_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   pen_move;
        logic   curve_end;
        logic   last;
    } res_t;

endpackage

### rtl/qbp_fifo.sv
// small first-word-fall-through queue built from registers
// generic width and depth; no package dependency
module qbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count missed a push");

endmodule

### rtl/qbp_front.sv
// front end: takes control points, keeps the last two and builds one job per item
// depends on qbp_pkg; feeds the job queue in front of qbp_back
module qbp_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  qbp_pkg::coord_t point_x,
    input  qbp_pkg::coord_t point_y,
    input  logic           first_point,
    input  logic           last_point,
    input  logic           cmd_full,
    output logic           cmd_push,
    output qbp_pkg::job_t  cmd_job
);
    import qbp_pkg::*;

    coord_t older_x_reg, older_y_reg, newer_x_reg, newer_y_reg;
    logic   open_reg;
    logic   accept;
    logic   start;

    assign accept   = push && !cmd_full;
    assign start    = first_point || !open_reg;
    assign cmd_push = accept;

    always_comb
    begin
        cmd_job.last_point = last_point;
        cmd_job.close      = last_point;
        cmd_job.cx         = point_x;
        cmd_job.cy         = point_y;
        if (start)
        begin
            // a move; the closing segment then uses the point three times
            cmd_job.is_move = 1'b1;
            cmd_job.ax      = point_x;
            cmd_job.ay      = point_y;
            cmd_job.bx      = point_x;
            cmd_job.by      = point_y;
        end
        else
        begin
            cmd_job.is_move = 1'b0;
            cmd_job.ax      = older_x_reg;
            cmd_job.ay      = older_y_reg;
            cmd_job.bx      = newer_x_reg;
            cmd_job.by      = newer_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_x_reg <= '0;
            older_y_reg <= '0;
            newer_x_reg <= '0;
            newer_y_reg <= '0;
            open_reg    <= 1'b0;
        end
        else if (accept)
        begin
            older_x_reg <= start ? point_x : newer_x_reg;
            older_y_reg <= start ? point_y : newer_y_reg;
            newer_x_reg <= point_x;
            newer_y_reg <= point_y;
            open_reg    <= !last_point;
        end
    end

    a_start_aligns: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && start) |=> (older_x_reg == newer_x_reg && older_y_reg == newer_y_reg))
        else $error("new curve did not seed both points");

    a_close_shuts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_point) |=> !open_reg)
        else $error("curve still open after its last point");

    a_job_close: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> (cmd_job.close == cmd_job.last_point))
        else $error("closing segment flag out of step with last point");

endmodule

### rtl/qbp_lane.sv
// one coordinate lane: weighted sum, round, divide by the scale, offset, saturate
// depends on qbp_pkg; two instances sit in qbp_back
module qbp_lane #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                       clk,
    input  logic [qbp_pkg::WGT_W-1:0]  t1,
    input  logic [qbp_pkg::WGT_W-1:0]  t2,
    input  logic [qbp_pkg::WGT_W-1:0]  t3,
    input  qbp_pkg::coord_t            a,
    input  qbp_pkg::coord_t            b,
    input  qbp_pkg::coord_t            c,
    input  logic                       round,
    input  qbp_pkg::coord_t            offset,
    output qbp_pkg::coord_t            coord
);
    import qbp_pkg::*;

    localparam int PROD_W = WGT_W + 1 + PT_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MAG_W  = 25;             // |sum| stays below 2^25
    localparam int Q_W    = MAG_W + RECIP_W - RECIP_SH;
    localparam int QS_W   = Q_W + 1;
    localparam int SAT_W  = ((COORD_WIDTH > QS_W + 1) ? COORD_WIDTH : QS_W + 1) + 1;
    localparam logic signed [SAT_W-1:0] SAT_HI =
        {{(SAT_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_LO =
        {{(SAT_W - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

    logic signed [PROD_W-1:0] pa_reg, pb_reg, pc_reg;
    logic                     round_reg;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  mag;
    logic [MAG_W-1:0]         m1_reg, m2_reg;
    logic                     neg1_reg, neg2_reg;
    logic [MAG_W+RECIP_W-1:0] qprod;
    logic [Q_W-1:0]           q0_reg;
    logic [MAG_W-1:0]         rem;
    logic signed [QS_W-1:0]   qmag;
    logic signed [QS_W-1:0]   q_reg;
    logic signed [SAT_W-1:0]  total;
    logic signed [SAT_W-1:0]  clipped;
    coord_t                   coord_reg;

    // stage 2: sum of products and rounding bias, split into sign and magnitude
    always_comb
    begin
        sum = SUM_W'(pa_reg) + SUM_W'(pb_reg) + SUM_W'(pc_reg)
            + (round_reg ? SUM_W'(HALF) : '0);
        mag = sum[SUM_W-1] ? -sum : sum;
    end

    // stage 3: reciprocal multiply, low by at most one
    assign qprod = m1_reg * RECIP_W'(RECIP);

    // stage 4: correct the quotient, then truncate toward zero
    always_comb
    begin
        rem  = m2_reg - MAG_W'(q0_reg * SCALE);
        qmag = QS_W'({1'b0, q0_reg}) + ((rem >= MAG_W'(SCALE)) ? QS_W'(1) : '0);
    end

    // stage 5: offset and clamp to the coordinate range
    always_comb
    begin
        total = SAT_W'(q_reg) + SAT_W'(offset);
        if (total > SAT_HI)
        begin
            clipped = SAT_HI;
        end
        else if (total < SAT_LO)
        begin
            clipped = SAT_LO;
        end
        else
        begin
            clipped = total;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg    <= $signed({1'b0, t3}) * a;
        pb_reg    <= $signed({1'b0, t2}) * b;
        pc_reg    <= $signed({1'b0, t1}) * c;
        round_reg <= round;
        m1_reg    <= mag[MAG_W-1:0];
        neg1_reg  <= sum[SUM_W-1];
        q0_reg    <= qprod[MAG_W+RECIP_W-1:RECIP_SH];
        m2_reg    <= m1_reg;
        neg2_reg  <= neg1_reg;
        q_reg     <= neg2_reg ? -qmag : qmag;
        coord_reg <= clipped[PT_W-1:0];
    end

    assign coord = coord_reg;

endmodule

### rtl/qbp_back.sv
// back end: steps through each job, one curve point per cycle into two lanes
// depends on qbp_pkg and qbp_lane; throttled by credits for the result queue
module qbp_back #(
    parameter int STEPS_PER_SEGMENT = 10,
    parameter int COORD_WIDTH       = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  qbp_pkg::job_t   cmd_job,
    input  logic            cmd_empty,
    output logic            cmd_pop,
    input  qbp_pkg::coord_t offset_x,
    input  qbp_pkg::coord_t offset_y,
    input  logic            out_pop,
    output logic            out_push,
    output qbp_pkg::res_t   out_res
);
    import qbp_pkg::*;

    localparam int STEP_W = $clog2(STEPS_PER_SEGMENT);
    localparam int PEND_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_CLOSE
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PEND_W-1:0] pending_reg, pending_next;
    job_t              job_reg;
    tag_t              tag_reg [LANE_LAT];
    tag_t              tag_in;

    logic [WGT_W-1:0]  t1_tab [STEPS_PER_SEGMENT];
    logic [WGT_W-1:0]  t2_tab [STEPS_PER_SEGMENT];
    logic [WGT_W-1:0]  t3_tab [STEPS_PER_SEGMENT];

    logic              issue;
    logic              phase_end;
    logic              item_end;
    logic              load;
    logic [WGT_W-1:0]  t1, t2, t3;
    coord_t            ax, ay, bx, by, cx, cy;
    logic              round;
    coord_t            lane_x, lane_y;

    // quadratic b-spline weights per step, in thousandths
    for (genvar g = 0; g < STEPS_PER_SEGMENT; g++)
    begin : g_wgt
        localparam int W  = SCALE * g / STEPS_PER_SEGMENT;
        localparam int U  = W - HALF;
        localparam int V  = U - HALF;
        localparam int T1 = W * W / (2 * SCALE);
        localparam int T2 = 3 * SCALE / 4 - U * U / SCALE;
        localparam int T3 = V * V / (2 * SCALE);
        assign t1_tab[g] = WGT_W'(T1);
        assign t2_tab[g] = WGT_W'(T2);
        assign t3_tab[g] = WGT_W'(T3);
    end

    assign issue = (state_reg != ST_IDLE) && (pending_reg < PEND_W'(OUT_DEPTH));

    always_comb
    begin
        phase_end = (step_reg == STEP_W'(STEPS_PER_SEGMENT - 1));
        t1    = t1_tab[step_reg];
        t2    = t2_tab[step_reg];
        t3    = t3_tab[step_reg];
        round = 1'b1;
        ax    = job_reg.ax;
        ay    = job_reg.ay;
        bx    = job_reg.bx;
        by    = job_reg.by;
        cx    = job_reg.cx;
        cy    = job_reg.cy;
        unique case (state_reg)
            ST_FIRST:
            begin
                if (job_reg.is_move)
                begin
                    // exact pass-through of the point, before the offset
                    phase_end = 1'b1;
                    t1    = '0;
                    t2    = WGT_W'(SCALE);
                    t3    = '0;
                    round = 1'b0;
                end
                item_end = phase_end && !job_reg.close;
            end
            ST_CLOSE:
            begin
                // closing segment counts the last point twice
                ax       = job_reg.bx;
                ay       = job_reg.by;
                bx       = job_reg.cx;
                by       = job_reg.cy;
                item_end = phase_end;
            end
            default:
            begin
                item_end = 1'b0;
            end
        endcase
    end

    assign load    = !cmd_empty && ((state_reg == ST_IDLE) || (issue && item_end));
    assign cmd_pop = load;

    always_comb
    begin
        tag_in.valid     = issue;
        tag_in.pen_move  = (state_reg == ST_FIRST) && job_reg.is_move;
        tag_in.last      = item_end;
        tag_in.curve_end = item_end && job_reg.last_point;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        if (load)
        begin
            state_next = ST_FIRST;
            step_next  = '0;
        end
        else if (issue && phase_end)
        begin
            step_next  = '0;
            state_next = (state_reg == ST_FIRST && job_reg.close) ? ST_CLOSE : ST_IDLE;
        end
        else if (issue)
        begin
            step_next = step_reg + STEP_W'(1);
        end
        pending_next = pending_reg + (issue ? PEND_W'(1) : '0) - (out_pop ? PEND_W'(1) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            pending_reg <= '0;
            for (int i = 0; i < LANE_LAT; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            pending_reg <= pending_next;
            tag_reg[0]  <= tag_in;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= cmd_job;
        end
    end

    qbp_lane #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_lane_x (
        .clk    (clk),
        .t1     (t1),
        .t2     (t2),
        .t3     (t3),
        .a      (ax),
        .b      (bx),
        .c      (cx),
        .round  (round),
        .offset (offset_x),
        .coord  (lane_x)
    );

    qbp_lane #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_lane_y (
        .clk    (clk),
        .t1     (t1),
        .t2     (t2),
        .t3     (t3),
        .a      (ay),
        .b      (by),
        .c      (cy),
        .round  (round),
        .offset (offset_y),
        .coord  (lane_y)
    );

    assign out_push          = tag_reg[LANE_LAT-1].valid;
    assign out_res.x         = lane_x;
    assign out_res.y         = lane_y;
    assign out_res.pen_move  = tag_reg[LANE_LAT-1].pen_move;
    assign out_res.curve_end = tag_reg[LANE_LAT-1].curve_end;
    assign out_res.last      = tag_reg[LANE_LAT-1].last;

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(OUT_DEPTH))
        else $error("result credits overrun");

    a_inflight_counted: assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg[LANE_LAT-1].valid |-> (pending_reg != '0))
        else $error("result in flight without a credit");

    a_close_only_if_asked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSE) |-> job_reg.close)
        else $error("closing segment on a job without last point");

    a_issue_tagged: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> tag_reg[0].valid)
        else $error("issued step lost its tag");

endmodule

### rtl/quadratic_bspline_points_core.sv
// top level of the quadratic b-spline point generator: config registers and queues
// depends on qbp_pkg, qbp_fifo, qbp_front and qbp_back
//
//  channel   direction  handshake            payload
//  input     in         push / full          point_x point_y first_point last_point
//  result    out        empty / pop          x y pen_move raster_op curve_end last
//  config    in         cfg_valid/cfg_ready  cfg_index cfg_data
//
// an item yields STEPS_PER_SEGMENT curve points, one for a plain first point,
// 2*STEPS_PER_SEGMENT for a last point and STEPS_PER_SEGMENT+1 for a lone point;
// the back end issues one curve point per cycle, when credits allow, through a five stage lane pair
// a taken item passes the job queue, job register and lane stages before its first result
// reset is asynchronous and clears curve state, queues and registers at once
// the result queue holds 8 items; issue stops when all slots are spoken for
module quadratic_bspline_points_core #(
    parameter int STEPS_PER_SEGMENT = 10,
    parameter int COORD_WIDTH       = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  qbp_pkg::coord_t point_x,
    input  qbp_pkg::coord_t point_y,
    input  logic            first_point,
    input  logic            last_point,
    output logic            empty,
    input  logic            pop,
    output qbp_pkg::coord_t x,
    output qbp_pkg::coord_t y,
    output logic            pen_move,
    output logic [1:0]      raster_op,
    output logic            curve_end,
    output logic            last,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);
    import qbp_pkg::*;

    coord_t     offset_x_reg, offset_y_reg;
    logic [1:0] pixel_fn_reg;
    logic       cfg_write;

    logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
    job_t       cmd_wjob, cmd_rjob;
    logic       out_push, out_full, out_pop;
    res_t       out_wres, out_rres;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            pixel_fn_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_OFFSET_X: offset_x_reg <= cfg_data;
                CFG_OFFSET_Y: offset_y_reg <= cfg_data;
                CFG_PIXEL_FN: pixel_fn_reg <= cfg_data[1:0];
                default:      ;
            endcase
        end
    end

    qbp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .point_x     (point_x),
        .point_y     (point_y),
        .first_point (first_point),
        .last_point  (last_point),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd_job     (cmd_wjob)
    );

    assign full = cmd_full;

    qbp_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wjob),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rjob),
        .empty (cmd_empty)
    );

    qbp_back #(
        .STEPS_PER_SEGMENT (STEPS_PER_SEGMENT),
        .COORD_WIDTH       (COORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_job   (cmd_rjob),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .offset_x  (offset_x_reg),
        .offset_y  (offset_y_reg),
        .out_pop   (out_pop),
        .out_push  (out_push),
        .out_res   (out_wres)
    );

    assign out_pop = pop && !empty;

    qbp_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wres),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rres),
        .empty (empty)
    );

    assign x         = out_rres.x;
    assign y         = out_rres.y;
    assign pen_move  = out_rres.pen_move;
    assign curve_end = out_rres.curve_end;
    assign last      = out_rres.last;
    // the user must change registers only while no item is outstanding; the block does not enforce this
    assign raster_op = pixel_fn_reg;

    a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result queue overflow");

    a_cfg_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_index == CFG_PIXEL_FN) |=> (raster_op == $past(cfg_data[1:0])))
        else $error("raster op not taken from write");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !cmd_push)
        else $error("job written into a full queue");

endmodule
